[rtl/aapr_pkg.sv]
// Shared types, widths and constants of the axis-angle point rotation pipeline.
package aapr_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned ANGLE_WIDTH = 16;
  localparam int unsigned AXIS_WIDTH  = 16;

  // sine/cosine series in unsigned Q.30
  localparam int unsigned FRAC = 30;
  localparam int unsigned XW   = 30;
  localparam int unsigned TW   = 31;
  localparam logic [31:0] PI30 = 32'd3373259426;

  localparam int unsigned SIN_STEPS = 5;
  localparam int unsigned COS_STEPS = 6;
  localparam int unsigned SIN_K [SIN_STEPS] = '{110, 72, 42, 20, 6};
  localparam int unsigned COS_K [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

  localparam int unsigned STEP_LAT = 3;
  localparam int unsigned SIN_PAD  = STEP_LAT * (COS_STEPS - SIN_STEPS) - 1;
  localparam int unsigned SC_LAT   = 3 + STEP_LAT * COS_STEPS + 1;
  localparam int unsigned MAT_LAT  = 4;
  localparam int unsigned XF_LAT   = 3;

  // sine/cosine in signed Q.28, matrix entries in signed Q.24
  localparam int unsigned SCW = 30;
  localparam int unsigned EW  = 30;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [AXIS_WIDTH-1:0]  axis_t;
  typedef logic signed [EW-1:0]          entry_t;
  typedef entry_t [8:0]                  mat_t;

  typedef struct packed {
    coord_t                 point_x;
    coord_t                 point_y;
    coord_t                 point_z;
    axis_t                  axis_x;
    axis_t                  axis_y;
    axis_t                  axis_z;
    logic [ANGLE_WIDTH-1:0] angle;
  } in_t;

  typedef struct packed {
    coord_t rot_x;
    coord_t rot_y;
    coord_t rot_z;
  } out_t;

  typedef struct packed {
    logic signed [SCW-1:0] s;
    logic signed [SCW-1:0] c;
  } sc_t;

endpackage

[rtl/aapr_step.sv]
// One series step t' = 1 - ((x2*t)>>30)/K over three register stages.
module aapr_step #(
  parameter int unsigned K = 2
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [aapr_pkg::XW-1:0] x2_i,
  input  logic [aapr_pkg::TW-1:0] t_i,
  output logic [aapr_pkg::XW-1:0] x2_o,
  output logic [aapr_pkg::TW-1:0] t_o
);

  localparam int unsigned XW   = aapr_pkg::XW;
  localparam int unsigned TW   = aapr_pkg::TW;
  localparam int unsigned FRAC = aapr_pkg::FRAC;
  localparam int unsigned QKW  = XW + 8;
  localparam logic [XW-1:0] RECIP = XW'((64'd1 << FRAC) / K);
  localparam logic [TW-1:0] ONE   = TW'(1) << FRAC;

  logic [XW+TW-1:0] prod_a;
  logic [2*XW-1:0]  prod_b;
  logic [QKW-1:0]   qk, rem;
  logic [XW-1:0]    q;

  logic [XW-1:0] p_a_q, x2_a_q, p_b_q, q0_b_q, x2_b_q, x2_c_q;
  logic [TW-1:0] t_c_q, t_c_d;

  assign prod_a = (XW+TW)'(x2_i) * (XW+TW)'(t_i);
  assign prod_b = (2*XW)'(p_a_q) * (2*XW)'(RECIP);

  // reciprocal quotient is at most one low: fix with one compare
  assign qk    = QKW'(q0_b_q) * QKW'(K);
  assign rem   = QKW'(p_b_q) - qk;
  assign q     = (rem >= QKW'(K)) ? q0_b_q + XW'(1) : q0_b_q;
  assign t_c_d = ONE - TW'(q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_a_q  <= prod_a[FRAC +: XW];
      x2_a_q <= x2_i;
      q0_b_q <= prod_b[FRAC +: XW];
      p_b_q  <= p_a_q;
      x2_b_q <= x2_a_q;
      t_c_q  <= t_c_d;
      x2_c_q <= x2_b_q;
    end
  end

  assign x2_o = x2_c_q;
  assign t_o  = t_c_q;

endmodule

[rtl/aapr_sincos.sv]
// Pipelined sine and cosine of a turn fraction, octant folded, series evaluated.
module aapr_sincos (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [aapr_pkg::ANGLE_WIDTH-1:0] angle_i,
  output aapr_pkg::sc_t                   sc_o
);

  localparam int unsigned AW      = aapr_pkg::ANGLE_WIDTH;
  localparam int unsigned XW      = aapr_pkg::XW;
  localparam int unsigned TW      = aapr_pkg::TW;
  localparam int unsigned FRAC    = aapr_pkg::FRAC;
  localparam int unsigned SCW     = aapr_pkg::SCW;
  localparam int unsigned RW      = AW - 2;
  localparam int unsigned PRW     = RW + 33;
  localparam int unsigned OCT_DLY = aapr_pkg::SC_LAT - 1;
  localparam int unsigned X_DLY   = aapr_pkg::STEP_LAT * aapr_pkg::SIN_STEPS + 1;
  localparam int unsigned S_DLY   = aapr_pkg::SIN_PAD + 1;
  localparam logic [RW-1:0] SPAN  = RW'(1) << (AW - 3);
  localparam logic [TW-1:0] ONE   = TW'(1) << FRAC;

  logic [2:0]      oct;
  logic [RW-1:0]   r_d, r_q;
  logic [PRW-1:0]  prod_r;
  logic [2*XW:0]   prod_x;
  logic [XW+TW-1:0] prod_s;
  logic [XW-1:0]   x_q, x2_q;
  logic [2:0]      oct_q [OCT_DLY];
  logic [XW-1:0]   x_pipe_q [X_DLY];
  logic [TW-1:0]   s0_q [S_DLY];
  logic [XW-1:0]   sin_x2 [aapr_pkg::SIN_STEPS+1];
  logic [TW-1:0]   sin_t  [aapr_pkg::SIN_STEPS+1];
  logic [XW-1:0]   cos_x2 [aapr_pkg::COS_STEPS+1];
  logic [TW-1:0]   cos_t  [aapr_pkg::COS_STEPS+1];
  logic [2:0]      oct_end;
  logic signed [32:0] s_sw, c_sw, s_m, c_m, s_r, c_r;
  aapr_pkg::sc_t   sc_d, sc_q;

  // fold into the first octant; odd octants count down from the octant end
  assign oct = angle_i[AW-1 -: 3];
  assign r_d = oct[0] ? SPAN - RW'(angle_i[AW-4:0]) : RW'(angle_i[AW-4:0]);

  assign prod_r = PRW'(r_q) * PRW'(aapr_pkg::PI30) + (PRW'(1) << (AW - 2));
  assign prod_x = (2*XW+1)'(x_q) * (2*XW+1)'(x_q) + ((2*XW+1)'(1) << (FRAC - 1));
  assign prod_s = (XW+TW)'(x_pipe_q[X_DLY-1]) * (XW+TW)'(sin_t[aapr_pkg::SIN_STEPS]);

  assign sin_x2[0] = x2_q;
  assign sin_t[0]  = ONE;
  assign cos_x2[0] = x2_q;
  assign cos_t[0]  = ONE;

  for (genvar i = 0; i < aapr_pkg::SIN_STEPS; i++) begin : g_sin
    aapr_step #(.K(aapr_pkg::SIN_K[i])) u_step (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x2_i  (sin_x2[i]),
      .t_i   (sin_t[i]),
      .x2_o  (sin_x2[i+1]),
      .t_o   (sin_t[i+1])
    );
  end

  for (genvar i = 0; i < aapr_pkg::COS_STEPS; i++) begin : g_cos
    aapr_step #(.K(aapr_pkg::COS_K[i])) u_step (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x2_i  (cos_x2[i]),
      .t_i   (cos_t[i]),
      .x2_o  (cos_x2[i+1]),
      .t_o   (cos_t[i+1])
    );
  end

  assign oct_end = oct_q[OCT_DLY-1];

  always_comb begin
    if (oct_end[0]) begin
      s_sw = $signed({2'b00, cos_t[aapr_pkg::COS_STEPS]});
      c_sw = $signed({2'b00, s0_q[S_DLY-1]});
    end else begin
      s_sw = $signed({2'b00, s0_q[S_DLY-1]});
      c_sw = $signed({2'b00, cos_t[aapr_pkg::COS_STEPS]});
    end
    case (oct_end[2:1])
      2'd1: begin
        s_m = c_sw;
        c_m = -s_sw;
      end
      2'd2: begin
        s_m = -s_sw;
        c_m = -c_sw;
      end
      2'd3: begin
        s_m = -c_sw;
        c_m = s_sw;
      end
      default: begin
        s_m = s_sw;
        c_m = c_sw;
      end
    endcase
    s_r    = s_m + 33'sd2;
    c_r    = c_m + 33'sd2;
    sc_d.s = $signed(s_r[SCW+1:2]);
    sc_d.c = $signed(c_r[SCW+1:2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q         <= r_d;
      oct_q[0]    <= oct;
      x_q         <= prod_r[AW-1 +: XW];
      x2_q        <= prod_x[FRAC +: XW];
      x_pipe_q[0] <= x_q;
      s0_q[0]     <= prod_s[FRAC +: TW];
      sc_q        <= sc_d;
      for (int i = 1; i < OCT_DLY; i++) begin
        oct_q[i] <= oct_q[i-1];
      end
      for (int i = 1; i < X_DLY; i++) begin
        x_pipe_q[i] <= x_pipe_q[i-1];
      end
      for (int i = 1; i < S_DLY; i++) begin
        s0_q[i] <= s0_q[i-1];
      end
    end
  end

  assign sc_o = sc_q;

endmodule

[rtl/aapr_matrix.sv]
// Rodrigues rotation matrix from axis, sine and cosine over four register stages.
module aapr_matrix (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  aapr_pkg::sc_t           sc_i,
  input  aapr_pkg::axis_t [2:0]   axis_i,
  output aapr_pkg::mat_t          mat_o
);

  localparam int unsigned AXW = aapr_pkg::AXIS_WIDTH;
  localparam int unsigned SCW = aapr_pkg::SCW;
  localparam int unsigned EW  = aapr_pkg::EW;
  localparam int unsigned VVW = 2 * AXW;
  localparam int unsigned VSW = AXW + SCW;
  localparam int unsigned DMW = VVW + 1;
  localparam int unsigned DPW = SCW + DMW;
  localparam int unsigned OPW = 2 * VVW;
  localparam int unsigned MW  = 38;
  localparam logic signed [VVW-1:0] ONE28 = VVW'(1) << 28;

  logic signed [VVW-1:0] vd_d [3], vo_d [3], vd_q [3], vo_q [3], vd2_q [3];
  logic signed [VSW-1:0] vs_d [3], vs_q [3], vs_rnd [3];
  logic signed [VVW-1:0] omc_d, omc_q;
  logic signed [SCW-1:0] c_q;
  logic signed [DMW-1:0] dm [3];
  logic signed [DPW-1:0] dp_d [3], dp_q [3], dp_rnd [3];
  logic signed [OPW-1:0] op_d [3], op_q [3], op_rnd [3];
  logic signed [31:0]    vsr_d [3], vsr_q [3];
  logic signed [MW-1:0]  rd [3], ro [3];
  logic signed [MW-1:0]  m_d [9], m_q [9], m_rnd [9];
  aapr_pkg::mat_t        mat_d, mat_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vd_d[k] = VVW'(axis_i[k]) * VVW'(axis_i[k]);
      vs_d[k] = VSW'(axis_i[k]) * VSW'(sc_i.s);
    end
    vo_d[0] = VVW'(axis_i[0]) * VVW'(axis_i[1]);
    vo_d[1] = VVW'(axis_i[1]) * VVW'(axis_i[2]);
    vo_d[2] = VVW'(axis_i[2]) * VVW'(axis_i[0]);
    omc_d   = ONE28 - VVW'(sc_i.c);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dm[k]     = DMW'(ONE28) - DMW'(vd_q[k]);
      dp_d[k]   = DPW'(c_q) * DPW'(dm[k]);
      op_d[k]   = OPW'(vo_q[k]) * OPW'(omc_q);
      vs_rnd[k] = vs_q[k] + VSW'(8192);
      vsr_d[k]  = $signed(vs_rnd[k][VSW-1:14]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dp_rnd[k] = dp_q[k] + (DPW'(1) << 27);
      op_rnd[k] = op_q[k] + (OPW'(1) << 27);
      rd[k]     = MW'($signed(dp_rnd[k][DPW-1:28]));
      ro[k]     = MW'($signed(op_rnd[k][OPW-1:28]));
    end
    // row-major entries; ro/vsr index 0:xy/x, 1:yz/y, 2:zx/z
    m_d[0] = MW'(vd2_q[0]) + rd[0];
    m_d[4] = MW'(vd2_q[1]) + rd[1];
    m_d[8] = MW'(vd2_q[2]) + rd[2];
    m_d[1] = ro[0] - MW'(vsr_q[2]);
    m_d[3] = ro[0] + MW'(vsr_q[2]);
    m_d[2] = ro[2] + MW'(vsr_q[1]);
    m_d[6] = ro[2] - MW'(vsr_q[1]);
    m_d[5] = ro[1] - MW'(vsr_q[0]);
    m_d[7] = ro[1] + MW'(vsr_q[0]);
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m_rnd[k] = m_q[k] + MW'(8);
      mat_d[k] = $signed(m_rnd[k][4 +: EW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        vd_q[k]  <= vd_d[k];
        vo_q[k]  <= vo_d[k];
        vs_q[k]  <= vs_d[k];
        vd2_q[k] <= vd_q[k];
        dp_q[k]  <= dp_d[k];
        op_q[k]  <= op_d[k];
        vsr_q[k] <= vsr_d[k];
      end
      omc_q <= omc_d;
      c_q   <= sc_i.c;
      for (int k = 0; k < 9; k++) begin
        m_q[k] <= m_d[k];
      end
      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule

[rtl/aapr_xform.sv]
// Matrix times point with split coordinates, rounding and saturation.
module aapr_xform (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  aapr_pkg::mat_t         mat_i,
  input  aapr_pkg::coord_t [2:0] point_i,
  output aapr_pkg::out_t         res_o
);

  localparam int unsigned CW  = aapr_pkg::COORD_WIDTH;
  localparam int unsigned EW  = aapr_pkg::EW;
  localparam int unsigned PW  = (CW > 25) ? CW : 25;
  localparam int unsigned PHW = PW - 24;
  localparam int unsigned HPW = EW + PHW;
  localparam int unsigned LPW = EW + 25;
  localparam int unsigned HW  = HPW + 2;
  localparam int unsigned LW  = LPW + 2;
  localparam int unsigned LRW = LW - 24;
  localparam int unsigned SW  = HW + 1;
  localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  logic signed [PW-1:0]  pe [3];
  logic signed [PHW-1:0] ph [3];
  logic signed [24:0]    pl [3];
  logic signed [HPW-1:0] hp_d [9], hp_q [9];
  logic signed [LPW-1:0] lp_d [9], lp_q [9];
  logic signed [HW-1:0]  hi_d [3], hi_q [3], hi2_q [3];
  logic signed [LW-1:0]  lo_d [3], lo_q [3], lo_rnd [3];
  logic signed [LRW-1:0] lor_q [3];
  logic signed [SW-1:0]  tot [3];
  aapr_pkg::coord_t      rot [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pe[j] = PW'(point_i[j]);
      ph[j] = $signed(pe[j][PW-1:24]);
      pl[j] = $signed({1'b0, pe[j][23:0]});
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        hp_d[i*3+j] = HPW'($signed(mat_i[i*3+j])) * HPW'(ph[j]);
        lp_d[i*3+j] = LPW'($signed(mat_i[i*3+j])) * LPW'(pl[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hi_d[i]   = HW'(hp_q[i*3]) + HW'(hp_q[i*3+1]) + HW'(hp_q[i*3+2]);
      lo_d[i]   = LW'(lp_q[i*3]) + LW'(lp_q[i*3+1]) + LW'(lp_q[i*3+2]);
      lo_rnd[i] = lo_q[i] + (LW'(1) << 23);
    end
  end

  // clamp to the coordinate range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = SW'(hi2_q[i]) + SW'(lor_q[i]);
      if (tot[i] > MAXV) begin
        rot[i] = MAXV[CW-1:0];
      end else if (tot[i] < MINV) begin
        rot[i] = MINV[CW-1:0];
      end else begin
        rot[i] = tot[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        hp_q[k] <= hp_d[k];
        lp_q[k] <= lp_d[k];
      end
      for (int i = 0; i < 3; i++) begin
        hi_q[i]  <= hi_d[i];
        lo_q[i]  <= lo_d[i];
        hi2_q[i] <= hi_q[i];
        lor_q[i] <= $signed(lo_rnd[i][LW-1:24]);
      end
    end
  end

  assign res_o.rot_x = rot[0];
  assign res_o.rot_y = rot[1];
  assign res_o.rot_z = rot[2];

endmodule

[rtl/axis_angle_point_rotation_unit.sv]
// Top level: input register, sine/cosine, matrix and transform pipeline, output queue.
//
// Rotates one point about a unit axis through the origin per word. The input
// word carries the point (signed Q16.16), the axis (signed Q1.14) and the angle
// (turn fraction); the output word carries the rotated point, saturated.
// Both channels use valid/ready; a word moves when both are high.
// Throughput: one word per cycle while the pipeline is not held, with no dependence between words.
// The path from input to output runs through the input register, 22 sine/cosine
// stages set by the six series steps of three stages each, 4 matrix stages,
// 3 transform stages and the write into the output queue.
// A two-word output queue sits behind the pipeline. The whole pipeline holds
// only while that queue is full and the receiver is not taking a word, so new
// input keeps being taken while one result waits.
// Reset clears all valid bits and the queue; no word is in flight after it.
module axis_angle_point_rotation_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  aapr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output aapr_pkg::out_t out_data_o
);

  localparam int unsigned LAT    = 1 + aapr_pkg::SC_LAT + aapr_pkg::MAT_LAT + aapr_pkg::XF_LAT;
  localparam int unsigned AX_DLY = aapr_pkg::SC_LAT;
  localparam int unsigned PT_DLY = aapr_pkg::SC_LAT + aapr_pkg::MAT_LAT;

  logic                   en, push, pop;
  logic [LAT-1:0]         vld_q;
  aapr_pkg::in_t          in_q;
  aapr_pkg::axis_t [2:0]  axis_dly_q [AX_DLY];
  aapr_pkg::coord_t [2:0] pt_dly_q [PT_DLY];
  aapr_pkg::sc_t          sc;
  aapr_pkg::mat_t         mat;
  aapr_pkg::out_t         res;
  aapr_pkg::out_t         mem_q [2];
  logic                   wr_q, rd_q;
  logic [1:0]             cnt_q;

  // advance unless the queue is full and nothing leaves it
  assign en         = (cnt_q != 2'd2) || out_ready_i;
  assign in_ready_o = en;
  assign push       = en && vld_q[LAT-1];
  assign pop        = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q          <= in_data_i;
      axis_dly_q[0] <= {in_q.axis_z, in_q.axis_y, in_q.axis_x};
      pt_dly_q[0]   <= {in_q.point_z, in_q.point_y, in_q.point_x};
      for (int i = 1; i < AX_DLY; i++) begin
        axis_dly_q[i] <= axis_dly_q[i-1];
      end
      for (int i = 1; i < PT_DLY; i++) begin
        pt_dly_q[i] <= pt_dly_q[i-1];
      end
    end
  end

  aapr_sincos u_sincos (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_q.angle),
    .sc_o    (sc)
  );

  aapr_matrix u_matrix (
    .clk_i  (clk_i),
    .en_i   (en),
    .sc_i   (sc),
    .axis_i (axis_dly_q[AX_DLY-1]),
    .mat_o  (mat)
  );

  aapr_xform u_xform (
    .clk_i   (clk_i),
    .en_i    (en),
    .mat_i   (mat),
    .point_i (pt_dly_q[PT_DLY-1]),
    .res_o   (res)
  );

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> cnt_q != 2'd2)
    else $error("output queue written while full");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o) && out_valid_o)
    else $error("waiting output word changed");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("queue count not decremented on pop");

endmodule
